FILE: sv/yuvrgb_pkg.sv
// shared constants, types and codes for the yuv 4:2:0 to rgb converter
`timescale 1ns / 1ps

package yuvrgb_pkg;

  localparam int FRAME_BYTES = 8192;

  localparam int ADDR_W = 17;
  localparam int PROD_W = 20;
  localparam int ACC_W  = 22;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd0;
  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd2;

  localparam logic [1:0] FMT_YU12 = 2'd0;
  localparam logic [1:0] FMT_YV12 = 2'd1;
  localparam logic [1:0] FMT_NV12 = 2'd2;
  localparam logic [1:0] FMT_NV21 = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [7:0] RST_FRAME_WIDTH  = 8'd8;
  localparam logic [7:0] RST_FRAME_HEIGHT = 8'd8;

  localparam prod_t COEF_Y  = 20'sd298;
  localparam prod_t COEF_RV = 20'sd409;
  localparam prod_t COEF_GU = 20'sd100;
  localparam prod_t COEF_GV = 20'sd208;
  localparam prod_t COEF_BU = 20'sd516;

  typedef struct packed {
    logic mul_en;
    logic sum_en;
    logic oor;
  } conv_ctrl_t;

endpackage

FILE: sv/yuvrgb_ram.sv
// generic byte store: one write port, two registered read ports
`timescale 1ns / 1ps

module yuvrgb_ram #(
  parameter int DataW = 8,
  parameter int Depth = 8192,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_a_i,
  input  logic [AddrW-1:0] raddr_a_i,
  output logic [DataW-1:0] rdata_a_o,
  input  logic             re_b_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [DataW-1:0] rdata_b_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_a_q;
  logic [DataW-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_a_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: sv/yuvrgb_conv.sv
// bt.601 integer conversion: registered products, then sums with saturation (black when out of range)
`timescale 1ns / 1ps

module yuvrgb_conv (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  yuvrgb_pkg::conv_ctrl_t ctrl_i,
  input  logic [7:0]             y_i,
  input  logic [7:0]             u_i,
  input  logic [7:0]             v_i,
  output logic [7:0]             red_o,
  output logic [7:0]             green_o,
  output logic [7:0]             blue_o,
  output logic                   out_of_range_o,
  output logic                   done_o
);

  logic signed [9:0] c_y;
  logic signed [9:0] c_u;
  logic signed [9:0] c_v;

  yuvrgb_pkg::prod_t p_y_q, p_rv_q, p_gu_q, p_gv_q, p_bu_q;
  yuvrgb_pkg::acc_t  acc_r, acc_g, acc_b;

  logic [7:0] red_q, green_q, blue_q;
  logic       oor_q;
  logic       done_q;

  function automatic logic [7:0] sat8(input yuvrgb_pkg::acc_t a);
    logic [7:0] res;
    if (a[yuvrgb_pkg::ACC_W-1]) begin
      res = 8'd0;
    end else if (|a[yuvrgb_pkg::ACC_W-2:16]) begin
      res = 8'd255;
    end else begin
      res = a[15:8];
    end
    return res;
  endfunction

  assign c_y = $signed({2'b00, y_i}) - 10'sd16;
  assign c_u = $signed({2'b00, u_i}) - 10'sd128;
  assign c_v = $signed({2'b00, v_i}) - 10'sd128;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      p_y_q  <= yuvrgb_pkg::PROD_W'(c_y) * yuvrgb_pkg::COEF_Y;
      p_rv_q <= yuvrgb_pkg::PROD_W'(c_v) * yuvrgb_pkg::COEF_RV;
      p_gu_q <= yuvrgb_pkg::PROD_W'(c_u) * yuvrgb_pkg::COEF_GU;
      p_gv_q <= yuvrgb_pkg::PROD_W'(c_v) * yuvrgb_pkg::COEF_GV;
      p_bu_q <= yuvrgb_pkg::PROD_W'(c_u) * yuvrgb_pkg::COEF_BU;
    end
  end

  assign acc_r = yuvrgb_pkg::ACC_W'(p_y_q) + yuvrgb_pkg::ACC_W'(p_rv_q) + 22'sd128;
  assign acc_g = yuvrgb_pkg::ACC_W'(p_y_q) - yuvrgb_pkg::ACC_W'(p_gu_q)
               - yuvrgb_pkg::ACC_W'(p_gv_q) + 22'sd128;
  assign acc_b = yuvrgb_pkg::ACC_W'(p_y_q) + yuvrgb_pkg::ACC_W'(p_bu_q) + 22'sd128;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_en) begin
      red_q   <= ctrl_i.oor ? 8'd0 : sat8(acc_r);
      green_q <= ctrl_i.oor ? 8'd0 : sat8(acc_g);
      blue_q  <= ctrl_i.oor ? 8'd0 : sat8(acc_b);
      oor_q   <= ctrl_i.oor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl_i.sum_en;
    end
  end

  assign red_o          = red_q;
  assign green_o        = green_q;
  assign blue_o         = blue_q;
  assign out_of_range_o = oor_q;
  assign done_o         = done_q;

endmodule

FILE: sv/yuv420_frame_to_rgb_converter_top.sv
// top level: frame store, sample address generation, control and configuration
`timescale 1ns / 1ps

// Holds one YUV 4:2:0 frame in a byte store and converts single pixels to
// saturated RGB888 (BT.601 integer). A write command (operation 0) stores one
// byte; busy stays low. A read command (operation 1) raises busy and accepts
// no new command while it forms the Y and chroma addresses, reads the store (Y
// and U share a cycle on the two read ports, V follows), forms the products and
// then the sums. The result appears for exactly one cycle with done_o high, as
// busy falls; the receiver cannot stall it and must take it then. Pixels or
// samples beyond the frame or the store give out_of_range_o with black.
// Configuration writes are accepted at any time but belong in idle periods.

module yuv420_frame_to_rgb_converter_top #(
  parameter int FRAME_BYTES = yuvrgb_pkg::FRAME_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        operation_i,
  input  logic [12:0] byte_address_i,
  input  logic [7:0]  byte_value_i,
  input  logic [6:0]  pixel_row_i,
  input  logic [6:0]  pixel_col_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        out_of_range_o,
  output logic        done_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int AddrW = $clog2(FRAME_BYTES);
  localparam yuvrgb_pkg::addr_t FrameLimit = yuvrgb_pkg::ADDR_W'(FRAME_BYTES);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ADDR  = 6'b000010,
    ST_RD_YU = 6'b000100,
    ST_RD_V  = 6'b001000,
    ST_MUL   = 6'b010000,
    ST_SUM   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [1:0] pixel_format_q;
  logic [7:0] frame_width_q;
  logic [7:0] frame_height_q;

  yuvrgb_pkg::addr_t base_q;
  yuvrgb_pkg::addr_t span_q;

  logic [6:0] row_q;
  logic [6:0] col_q;

  yuvrgb_pkg::addr_t ya_d, ua_d, va_d;
  yuvrgb_pkg::addr_t ya_q, ua_q, va_q;
  yuvrgb_pkg::addr_t planar_a, pair_a, wr_addr;
  logic              oor_d, oor_q;

  logic       accept;
  logic       wr_en;
  logic [7:0] y_rd, b_rd;
  logic [7:0] u_q;

  yuvrgb_pkg::conv_ctrl_t conv_ctrl;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_format_q <= yuvrgb_pkg::FMT_YU12;
      frame_width_q  <= yuvrgb_pkg::RST_FRAME_WIDTH;
      frame_height_q <= yuvrgb_pkg::RST_FRAME_HEIGHT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        yuvrgb_pkg::CFG_PIXEL_FORMAT: pixel_format_q <= cfg_data_i[1:0];
        yuvrgb_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        yuvrgb_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // plane size and chroma plane size
  always_ff @(posedge clk_i) begin
    base_q <= yuvrgb_pkg::addr_t'(frame_width_q) * yuvrgb_pkg::addr_t'(frame_height_q);
    span_q <= yuvrgb_pkg::addr_t'(frame_width_q[7:1])
            * yuvrgb_pkg::addr_t'(frame_height_q[7:1]);
  end

  // command handshake
  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign wr_addr = yuvrgb_pkg::addr_t'(byte_address_i);
  assign wr_en   = accept && (operation_i == yuvrgb_pkg::OP_WRITE) && (wr_addr < FrameLimit);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q <= pixel_row_i;
      col_q <= pixel_col_i;
    end
  end

  // sample addresses
  always_comb begin
    ya_d     = yuvrgb_pkg::addr_t'(row_q) * yuvrgb_pkg::addr_t'(frame_width_q)
             + yuvrgb_pkg::addr_t'(col_q);
    planar_a = base_q
             + yuvrgb_pkg::addr_t'(row_q[6:1]) * yuvrgb_pkg::addr_t'(frame_width_q[7:1])
             + yuvrgb_pkg::addr_t'(col_q[6:1]);
    pair_a   = base_q
             + yuvrgb_pkg::addr_t'(row_q[6:1]) * yuvrgb_pkg::addr_t'(frame_width_q)
             + yuvrgb_pkg::addr_t'({col_q[6:1], 1'b0});
    case (pixel_format_q)
      yuvrgb_pkg::FMT_YU12: begin
        ua_d = planar_a;
        va_d = planar_a + span_q;
      end
      yuvrgb_pkg::FMT_YV12: begin
        va_d = planar_a;
        ua_d = planar_a + span_q;
      end
      yuvrgb_pkg::FMT_NV12: begin
        ua_d = pair_a;
        va_d = pair_a + yuvrgb_pkg::addr_t'(1);
      end
      default: begin
        va_d = pair_a;
        ua_d = pair_a + yuvrgb_pkg::addr_t'(1);
      end
    endcase
    oor_d = ({1'b0, row_q} >= frame_height_q) || ({1'b0, col_q} >= frame_width_q)
         || (ya_d >= FrameLimit) || (ua_d >= FrameLimit) || (va_d >= FrameLimit);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ADDR) begin
      ya_q  <= ya_d;
      ua_q  <= ua_d;
      va_q  <= va_d;
      oor_q <= oor_d;
    end
    if (state_q == ST_RD_V) begin
      u_q <= b_rd;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (operation_i == yuvrgb_pkg::OP_READ)) begin
          state_d = ST_ADDR;
        end
      end
      ST_ADDR:  state_d = ST_RD_YU;
      ST_RD_YU: state_d = ST_RD_V;
      ST_RD_V:  state_d = ST_MUL;
      ST_MUL:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  yuvrgb_ram #(
    .DataW (8),
    .Depth (FRAME_BYTES)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (wr_addr[AddrW-1:0]),
    .wdata_i   (byte_value_i),
    .re_a_i    (state_q == ST_RD_YU),
    .raddr_a_i (ya_q[AddrW-1:0]),
    .rdata_a_o (y_rd),
    .re_b_i    ((state_q == ST_RD_YU) || (state_q == ST_RD_V)),
    .raddr_b_i ((state_q == ST_RD_V) ? va_q[AddrW-1:0] : ua_q[AddrW-1:0]),
    .rdata_b_o (b_rd)
  );

  assign conv_ctrl.mul_en = (state_q == ST_MUL);
  assign conv_ctrl.sum_en = (state_q == ST_SUM);
  assign conv_ctrl.oor    = oor_q;

  yuvrgb_conv u_conv (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (conv_ctrl),
    .y_i            (y_rd),
    .u_i            (u_q),
    .v_i            (b_rd),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .out_of_range_o (out_of_range_o),
    .done_o         (done_o)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("sequencer state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result beat while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (operation_i == yuvrgb_pkg::OP_READ)) |-> ##6 done_o)
    else $error("read result beat missing");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_of_range_o) |-> ((red_o == 8'd0) && (green_o == 8'd0) && (blue_o == 8'd0)))
    else $error("out of range pixel not black");
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_en |-> (state_q == ST_IDLE))
    else $error("store write during read");
`endif

endmodule
